[rtl/core/lsfs_pkg.sv]
// Shared types and constants for the LED strip frame serializer.
`timescale 1ns / 1ps
`default_nettype none
package lsfs_pkg;

	// Sizes of the fixed payload fields.
	localparam int unsigned COLOR_W   = 8;
	localparam int unsigned COUNT_W   = 8;
	localparam int unsigned PULSE_W   = 5;
	localparam int unsigned CHUNK_W   = 8;
	localparam int unsigned LEN_W     = 4;
	localparam int unsigned STEP_W    = 4;

	// Default strip length limit; the LED count saturates here.
	localparam int unsigned MAX_LEDS_DEF = 255;

	// LEDs covered by one end-frame pulse, and pulses in a full chunk.
	localparam int unsigned LEDS_PER_PULSE = 16;
	localparam logic [LEN_W-1:0] FULL_LEN  = 4'd8;

	// Depth of the request queue between front and back; a power of two.
	localparam int unsigned QDEPTH = 2;

	// Configuration port.
	localparam int unsigned ADDR_W = 3;
	localparam int unsigned DATA_W = 32;
	localparam logic [0:0]  REG_BRIGHTNESS = 1'b0;
	localparam logic [7:0]  BRIGHTNESS_RST = 8'hFF;

	// Chunk steps of one LED request.
	localparam logic [STEP_W-1:0] STEP_START0 = 4'd0;
	localparam logic [STEP_W-1:0] STEP_START3 = 4'd3;
	localparam logic [STEP_W-1:0] STEP_HDR    = 4'd4;
	localparam logic [STEP_W-1:0] STEP_BLUE   = 4'd5;
	localparam logic [STEP_W-1:0] STEP_GREEN  = 4'd6;
	localparam logic [STEP_W-1:0] STEP_RED    = 4'd7;
	localparam logic [STEP_W-1:0] STEP_END0   = 4'd8;
	localparam logic [STEP_W-1:0] STEP_END1   = 4'd9;

	// One classified LED request as it travels from front to back.
	typedef struct packed {
		logic [COLOR_W-1:0] blue;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] red;
		logic               start;
		logic [PULSE_W-1:0] pulses;
	} led_req_t;

	// Queue status seen by the producer and consumer.
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage
`default_nettype wire

[rtl/core/lsfs_front.sv]
// Front end: accepts LED colors and tracks frame state and LED count.
`timescale 1ns / 1ps
`default_nettype none
module lsfs_front #(
	parameter int unsigned MAX_LEDS = lsfs_pkg::MAX_LEDS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_stall,
	input  wire  [lsfs_pkg::COLOR_W-1:0]     blue,
	input  wire  [lsfs_pkg::COLOR_W-1:0]     green,
	input  wire  [lsfs_pkg::COLOR_W-1:0]     red,
	input  wire                              last_led,
	input  lsfs_pkg::q_status_t              q_stat,
	output logic                             push,
	output lsfs_pkg::led_req_t               push_req
);

	localparam logic [lsfs_pkg::COUNT_W-1:0] MaxCount = lsfs_pkg::COUNT_W'(MAX_LEDS);
	localparam logic [lsfs_pkg::COUNT_W:0]   PulseRound =
		(lsfs_pkg::COUNT_W+1)'(lsfs_pkg::LEDS_PER_PULSE - 1);

	logic [lsfs_pkg::COUNT_W-1:0] led_count_q;
	logic                         in_frame_q;
	logic [lsfs_pkg::COUNT_W-1:0] count_next;
	logic [lsfs_pkg::COUNT_W:0]   count_round;

	// Accept whenever the queue has room.
	assign in_stall = q_stat.full;
	assign push     = in_valid && !in_stall;

	// Saturating count including this LED, and the end-frame pulse count.
	assign count_next  = (led_count_q < MaxCount) ? led_count_q + 1'b1 : led_count_q;
	assign count_round = {1'b0, count_next} + PulseRound;

	always_comb begin
		push_req.blue   = blue;
		push_req.green  = green;
		push_req.red    = red;
		push_req.start  = !in_frame_q;
		push_req.pulses = last_led ? count_round[lsfs_pkg::COUNT_W -: lsfs_pkg::PULSE_W]
		                           : '0;
	end

	// Frame state: the last LED closes the frame and clears the count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_count_q <= '0;
			in_frame_q  <= 1'b0;
		end else if (push) begin
			if (last_led) begin
				led_count_q <= '0;
				in_frame_q  <= 1'b0;
			end else begin
				led_count_q <= count_next;
				in_frame_q  <= 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

[rtl/core/lsfs_queue.sv]
// Short request queue between the front end and the chunk sequencer.
`timescale 1ns / 1ps
`default_nettype none
module lsfs_queue (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  lsfs_pkg::led_req_t   push_req,
	input  wire                  pop,
	output lsfs_pkg::led_req_t   head_req,
	output lsfs_pkg::q_status_t  q_stat
);

	localparam int unsigned PtrW = $clog2(lsfs_pkg::QDEPTH);
	localparam int unsigned CntW = $clog2(lsfs_pkg::QDEPTH + 1);
	localparam logic [CntW-1:0] Depth = CntW'(lsfs_pkg::QDEPTH);

	lsfs_pkg::led_req_t mem_q [lsfs_pkg::QDEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign head_req     = mem_q[rd_ptr_q];
	assign q_stat.full  = (count_q == Depth);
	assign q_stat.empty = (count_q == '0);

	// Storage needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_req;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

[rtl/core/lsfs_back.sv]
// Back end: walks queued requests into serial chunks, one per unstalled cycle.
`timescale 1ns / 1ps
`default_nettype none
module lsfs_back (
	input  wire                              clk,
	input  wire                              arst_n,
	input  lsfs_pkg::led_req_t               head_req,
	input  lsfs_pkg::q_status_t              q_stat,
	output logic                             pop,
	input  wire  [lsfs_pkg::COLOR_W-1:0]     brightness,
	output logic                             out_valid,
	input  wire                              out_stall,
	output logic [lsfs_pkg::CHUNK_W-1:0]     chunk_bits,
	output logic [lsfs_pkg::LEN_W-1:0]       chunk_len,
	output logic                             last_chunk
);

	localparam logic [lsfs_pkg::PULSE_W-1:0] FullPulses =
		lsfs_pkg::PULSE_W'(lsfs_pkg::FULL_LEN);

	logic [lsfs_pkg::STEP_W-1:0]  step_q;
	logic [lsfs_pkg::STEP_W-1:0]  cur_step;
	logic [lsfs_pkg::STEP_W-1:0]  next_step;
	logic [lsfs_pkg::CHUNK_W-1:0] bits_c;
	logic [lsfs_pkg::LEN_W-1:0]   len_c;
	logic                         last_c;
	logic                         load;
	logic                         out_valid_q;
	logic [lsfs_pkg::CHUNK_W-1:0] chunk_bits_q;
	logic [lsfs_pkg::LEN_W-1:0]   chunk_len_q;
	logic                         last_chunk_q;
	logic [lsfs_pkg::PULSE_W-1:0] rem_pulses;

	// A request without a start frame begins at its header byte.
	assign cur_step = (step_q == lsfs_pkg::STEP_START0 && !head_req.start)
	                  ? lsfs_pkg::STEP_HDR : step_q;
	assign rem_pulses = head_req.pulses - FullPulses;

	// Chunk contents, end flag and successor of the current step.
	always_comb begin
		bits_c    = '0;
		len_c     = lsfs_pkg::FULL_LEN;
		last_c    = 1'b0;
		next_step = cur_step + 1'b1;
		case (cur_step) inside
			[lsfs_pkg::STEP_START0:lsfs_pkg::STEP_START3]: begin
				bits_c = '0;
			end
			lsfs_pkg::STEP_HDR: begin
				bits_c = brightness;
			end
			lsfs_pkg::STEP_BLUE: begin
				bits_c = head_req.blue;
			end
			lsfs_pkg::STEP_GREEN: begin
				bits_c = head_req.green;
			end
			lsfs_pkg::STEP_RED: begin
				bits_c = head_req.red;
				last_c = (head_req.pulses == '0);
			end
			lsfs_pkg::STEP_END0: begin
				if (head_req.pulses > FullPulses) begin
					len_c = lsfs_pkg::FULL_LEN;
				end else begin
					len_c  = head_req.pulses[lsfs_pkg::LEN_W-1:0];
					last_c = 1'b1;
				end
			end
			lsfs_pkg::STEP_END1: begin
				len_c  = rem_pulses[lsfs_pkg::LEN_W-1:0];
				last_c = 1'b1;
			end
			default: begin
				last_c = 1'b1;
			end
		endcase
	end

	// A new chunk enters the output register when it is free or being taken.
	assign load = !q_stat.empty && (!out_valid_q || !out_stall);
	assign pop  = load && last_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= lsfs_pkg::STEP_START0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				step_q <= last_c ? lsfs_pkg::STEP_START0 : next_step;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (load) begin
			chunk_bits_q <= bits_c;
			chunk_len_q  <= len_c;
			last_chunk_q <= last_c;
		end
	end

	assign out_valid  = out_valid_q;
	assign chunk_bits = chunk_bits_q;
	assign chunk_len  = chunk_len_q;
	assign last_chunk = last_chunk_q;

endmodule
`default_nettype wire

[rtl/core/led_strip_frame_serializer.sv]
// Top level of the LED strip frame serializer with its register port.
//
//  Channel   Direction  Handshake            Payload
//  in        request    in_valid/in_stall    blue, green, red, last_led
//  out       result     out_valid/out_stall  chunk_bits, chunk_len, last_chunk
//  config    APB        psel/penable/pready  paddr, pwdata, prdata
//
// The back end emits one chunk per unstalled cycle: 4 chunks per LED, 4 more for the
// start frame of a new frame, and 1 or 2 more for the end frame, so 4 to 10.
// The front end classifies each LED and queues up to two requests.
// Reset clears frame state, queue and output valid; brightness resets to 0xFF.
// A stall on the output holds the current chunk; the queue fills, then stalls input.
`timescale 1ns / 1ps
`default_nettype none
module led_strip_frame_serializer #(
	parameter int unsigned MAX_LEDS = lsfs_pkg::MAX_LEDS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              psel,
	input  wire                              penable,
	input  wire                              pwrite,
	input  wire  [lsfs_pkg::ADDR_W-1:0]      paddr,
	input  wire  [lsfs_pkg::DATA_W-1:0]      pwdata,
	output logic [lsfs_pkg::DATA_W-1:0]      prdata,
	output logic                             pready,
	input  wire                              in_valid,
	output logic                             in_stall,
	input  wire  [lsfs_pkg::COLOR_W-1:0]     blue,
	input  wire  [lsfs_pkg::COLOR_W-1:0]     green,
	input  wire  [lsfs_pkg::COLOR_W-1:0]     red,
	input  wire                              last_led,
	output logic                             out_valid,
	input  wire                              out_stall,
	output logic [lsfs_pkg::CHUNK_W-1:0]     chunk_bits,
	output logic [lsfs_pkg::LEN_W-1:0]       chunk_len,
	output logic                             last_chunk
);

	logic [lsfs_pkg::COLOR_W-1:0] brightness_q;
	logic                         reg_sel;
	logic                         push;
	logic                         pop;
	lsfs_pkg::led_req_t           push_req;
	lsfs_pkg::led_req_t           head_req;
	lsfs_pkg::q_status_t          q_stat;

	// Register decode: the word index is the address above the byte offset.
	assign pready  = 1'b1;
	assign reg_sel = (paddr[lsfs_pkg::ADDR_W-1] == lsfs_pkg::REG_BRIGHTNESS);

	always_comb begin
		prdata = '0;
		if (reg_sel) begin
			prdata = {{(lsfs_pkg::DATA_W - lsfs_pkg::COLOR_W){1'b0}}, brightness_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q <= lsfs_pkg::BRIGHTNESS_RST;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			brightness_q <= pwdata[lsfs_pkg::COLOR_W-1:0];
		end
	end

	lsfs_front #(
		.MAX_LEDS (MAX_LEDS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.blue     (blue),
		.green    (green),
		.red      (red),
		.last_led (last_led),
		.q_stat   (q_stat),
		.push     (push),
		.push_req (push_req)
	);

	lsfs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_req (push_req),
		.pop      (pop),
		.head_req (head_req),
		.q_stat   (q_stat)
	);

	lsfs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_req   (head_req),
		.q_stat     (q_stat),
		.pop        (pop),
		.brightness (brightness_q),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.chunk_bits (chunk_bits),
		.chunk_len  (chunk_len),
		.last_chunk (last_chunk)
	);

	// A shown chunk always has between one and eight pulses.
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (chunk_len != '0 && chunk_len <= lsfs_pkg::FULL_LEN))
		else $error("chunk length out of range");

	// Only the final chunk of a request can be short.
	a_short_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && chunk_len != lsfs_pkg::FULL_LEN) |-> last_chunk)
		else $error("short chunk before end of request");

	// Short chunks belong to the end frame and carry zero data.
	a_short_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && chunk_len != lsfs_pkg::FULL_LEN) |-> (chunk_bits == '0))
		else $error("end frame chunk carries data");

	// No request leaves the queue while it is empty.
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("pop from empty queue");

endmodule
`default_nettype wire

[tb/sv/led_frame_scoreboard_pkg.sv]
// Scoreboard that predicts and checks the serial chunks of the LED strip frame serializer.
`timescale 1ns / 1ps
package led_frame_scoreboard_pkg;
	import lsfs_pkg::*;

	// One serial chunk as it leaves the block.
	typedef struct packed {
		logic [CHUNK_W-1:0] bits;
		logic [LEN_W-1:0]   len;
		logic               last_chunk;
	} chunk_t;

	class led_frame_scoreboard;
		logic [COLOR_W-1:0] brightness;
		logic [COUNT_W-1:0] led_count;
		bit                 in_frame;
		chunk_t             pending_chunks[$];
		int unsigned        mismatches;

		function new();
			brightness = BRIGHTNESS_RST;
			led_count  = '0;
			in_frame   = 1'b0;
			mismatches = 0;
		endfunction

		task report_mismatch(input string msg);
			$display("%0t: mismatch: %s", $time, msg);
			mismatches++;
		endtask

		function void push_chunk(input logic [CHUNK_W-1:0] bits,
			input logic [LEN_W-1:0] len, input logic is_last);
			chunk_t c;
			c.bits       = bits;
			c.len        = len;
			c.last_chunk = is_last;
			pending_chunks.push_back(c);
		endfunction

		// Work out every chunk that one accepted LED request causes.
		function void note_led(input logic [COLOR_W-1:0] blue, input logic [COLOR_W-1:0] green,
			input logic [COLOR_W-1:0] red, input logic last_led);
			int unsigned pulses;
			int unsigned len;
			// A new frame opens with 32 zero bits.
			if (!in_frame) begin
				for (int i = 0; i < 4; i++)
					push_chunk('0, FULL_LEN, 1'b0);
				in_frame = 1'b1;
			end
			push_chunk(brightness, FULL_LEN, 1'b0);
			push_chunk(blue, FULL_LEN, 1'b0);
			push_chunk(green, FULL_LEN, 1'b0);
			push_chunk(red, FULL_LEN, !last_led);
			// The count stops at the strip limit, so the end frame never exceeds 16 pulses.
			if (led_count < MAX_LEDS_DEF)
				led_count++;
			if (last_led) begin
				pulses = (int'(led_count) + LEDS_PER_PULSE - 1) / LEDS_PER_PULSE;
				while (pulses > 0) begin
					len = (pulses > 8) ? 8 : pulses;
					push_chunk('0, LEN_W'(len), pulses == len);
					pulses -= len;
				end
				led_count = '0;
				in_frame  = 1'b0;
			end
		endfunction

		// Compare one accepted chunk with the oldest prediction.
		task check_chunk(input logic [CHUNK_W-1:0] bits, input logic [LEN_W-1:0] len,
			input logic last_chunk);
			chunk_t want;
			if (pending_chunks.size() == 0) begin
				report_mismatch($sformatf("unexpected chunk bits=%h len=%0d last=%b",
					bits, len, last_chunk));
				return;
			end
			want = pending_chunks.pop_front();
			if (bits !== want.bits)
				report_mismatch($sformatf("chunk_bits %h, want %h", bits, want.bits));
			if (len !== want.len)
				report_mismatch($sformatf("chunk_len %0d, want %0d", len, want.len));
			if (last_chunk !== want.last_chunk)
				report_mismatch($sformatf("last_chunk %b, want %b", last_chunk, want.last_chunk));
		endtask
	endclass

endpackage

[tb/sv/tb_top.sv]
// Top-level testbench of the LED strip frame serializer: stimulus, register writes and checks.
`timescale 1ns / 1ps
module tb_top;
	import lsfs_pkg::*;
	import led_frame_scoreboard_pkg::*;

	localparam logic [ADDR_W-1:0] BRIGHTNESS_ADDR = ADDR_W'(4 * REG_BRIGHTNESS);
	localparam int unsigned QUIET_LIMIT  = 2000;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned TAIL_CYCLES   = 20;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic psel    = 1'b0;
	logic penable = 1'b0;
	logic pwrite  = 1'b0;
	logic [ADDR_W-1:0] paddr  = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [COLOR_W-1:0] blue  = '0;
	logic [COLOR_W-1:0] green = '0;
	logic [COLOR_W-1:0] red   = '0;
	logic last_led  = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [CHUNK_W-1:0] chunk_bits;
	logic [LEN_W-1:0]   chunk_len;
	logic last_chunk;

	int unsigned send_idle_pct = 0;
	int unsigned stall_pct     = 0;
	int unsigned quiet_cycles;
	led_frame_scoreboard sb;

	led_strip_frame_serializer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.blue      (blue),
		.green     (green),
		.red       (red),
		.last_led  (last_led),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.chunk_bits(chunk_bits),
		.chunk_len (chunk_len),
		.last_chunk(last_chunk)
	);

	always #1 clk = ~clk;

	// The receiver stalls at random with the current probability.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Watch both channels: note each request, check each chunk.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_led(blue, green, red, last_led);
		if (arst_n && out_valid && !out_stall)
			sb.check_chunk(chunk_bits, chunk_len, last_chunk);
	end

	// Give up when neither channel moves for too long.
	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("FAILURE");
		$finish;
	end

	task automatic apb_access(input logic is_write, input logic [ADDR_W-1:0] addr,
		input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= is_write;
		paddr   <= addr;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Read the brightness register back and compare it with the predicted value.
	task automatic check_brightness();
		logic [DATA_W-1:0] word;
		apb_access(1'b0, BRIGHTNESS_ADDR, '0, word);
		if (word[COLOR_W-1:0] !== sb.brightness)
			sb.report_mismatch($sformatf("brightness reads %h, want %h",
				word[COLOR_W-1:0], sb.brightness));
	endtask

	task automatic set_brightness(input logic [COLOR_W-1:0] value);
		logic [DATA_W-1:0] unused;
		apb_access(1'b1, BRIGHTNESS_ADDR, DATA_W'(value), unused);
		sb.brightness = value;
		check_brightness();
	endtask

	// Offer one LED request, after a random gap, and hold it until it is taken.
	task automatic send_led(input logic [COLOR_W-1:0] b, input logic [COLOR_W-1:0] g,
		input logic [COLOR_W-1:0] r, input logic is_last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		blue     <= b;
		green    <= g;
		red      <= r;
		last_led <= is_last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic send_frame(input int unsigned count);
		for (int unsigned i = 0; i < count; i++)
			send_led(COLOR_W'($urandom_range(255)), COLOR_W'($urandom_range(255)),
				COLOR_W'($urandom_range(255)), i == count - 1);
	endtask

	// Mostly short frames, sometimes a longer one; now and then a frame is left open.
	task automatic send_random_frames(input int unsigned budget);
		int unsigned sent;
		int unsigned count;
		sent = 0;
		while (sent < budget) begin
			count = ($urandom_range(9) == 0) ? $urandom_range(48, 17) : $urandom_range(16, 1);
			send_frame(count);
			sent += count;
		end
		if ($urandom_range(1) == 1) begin
			count = $urandom_range(3, 1);
			for (int unsigned i = 0; i < count; i++)
				send_led(COLOR_W'($urandom_range(255)), COLOR_W'($urandom_range(255)),
					COLOR_W'($urandom_range(255)), 1'b0);
		end
	endtask

	// Stop offering requests and wait until every predicted chunk has arrived.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_chunks.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset brightness, no idling: extremes, all-black frames and a two-pulse end frame.
		check_brightness();
		send_led(8'hFF, 8'hFF, 8'hFF, 1'b1);
		send_led(8'h00, 8'h00, 8'h00, 1'b1);
		send_led(8'hAA, 8'h55, 8'h0F, 1'b0);
		send_led(8'h55, 8'hAA, 8'hF0, 1'b0);
		send_led(8'h00, 8'h00, 8'h00, 1'b1);
		send_frame(17);
		send_random_frames(14);
		drain();

		// Zero brightness, sender idling.
		set_brightness(8'h00);
		send_idle_pct = 51;
		stall_pct     = 0;
		send_random_frames(14);
		drain();

		// Full brightness, receiver stalling.
		set_brightness(8'hFF);
		send_idle_pct = 0;
		stall_pct     = 51;
		send_random_frames(14);
		drain();

		// Usual header form, both sides idling.
		set_brightness({3'b111, 5'($urandom_range(31))});
		send_idle_pct = 22;
		stall_pct     = 22;
		send_random_frames(14);
		drain();

		// Any brightness value, no idling.
		set_brightness(COLOR_W'($urandom_range(255)));
		send_idle_pct = 0;
		stall_pct     = 0;
		send_random_frames(14);
		send_frame($urandom_range(8, 1));

		// Let the last chunks come out, then judge the run.
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_chunks.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_chunks.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
